[rtl/lfa_pkg.sv]
// Shared types, codes and helper functions for the LIFO free-list slot allocator.
package lfa_pkg;

  // Bus widths of the streaming ports.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 136;

  // The active map is kept as rows of this many flags.
  localparam int MAP_WORD_W = 32;
  localparam int MAP_BIT_W  = $clog2(MAP_WORD_W);

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_NEXT   = 2'd2,
    MODE_REWIND = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_RANGE     = 3'd2,
    STAT_INACTIVE  = 3'd3,
    STAT_EXHAUSTED = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_ALLOC_MAP,
    S_ALLOC_UPD,
    S_FREE_UPD,
    S_SCAN1,
    S_SCAN2,
    S_CHECK,
    S_MORE,
    S_OUT
  } state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FETCH,
    OP_ALLOC_MAP,
    OP_ALLOC_UPD,
    OP_FREE_UPD,
    OP_SCAN1,
    OP_SCAN2,
    OP_CHECK,
    OP_MORE,
    OP_OUT
  } dp_op_t;

  // Conditions the datapath reports back to the controller.
  typedef struct packed {
    mode_t mode;
    logic  depth_zero;
    logic  slot_bad;
    logic  pos_end;
    logic  bit_set;
    logic  word_hit;
    logic  row_hit;
  } dp_flags_t;

  // Event counter increment that sticks at the maximum.
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Index of the lowest set bit of a map row, zero when the row is empty.
  function automatic logic [MAP_BIT_W-1:0] first_set(input logic [MAP_WORD_W-1:0] w);
    logic [MAP_BIT_W-1:0] idx;
    idx = '0;
    for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = MAP_BIT_W'(i);
    end
    first_set = idx;
  endfunction

endpackage

[rtl/lfa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module lfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in program order; the read returns the old contents on a collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lfa_dp.sv]
// Datapath: free stack, active map rows, counters, scan position and result register.
module lfa_dp import lfa_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data,
  input  logic [1:0]  in_mode,
  input  logic [9:0]  in_slot,
  input  dp_op_t      op,
  output dp_flags_t   flags,
  output status_t     status,
  output logic [9:0]  slot_out,
  output logic [10:0] free_slots,
  output logic [10:0] active_slots,
  output logic        more_active,
  output logic [31:0] alloc_total,
  output logic [31:0] free_total,
  output logic [31:0] fail_total
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int BIT_W  = MAP_BIT_W;
  localparam int ROWS   = (MAX_SLOTS + MAP_WORD_W - 1) / MAP_WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [CNT_W-1:0] RESET_POOL = CNT_W'((MAX_SLOTS < 1024) ? MAX_SLOTS : 1024);

  // Pool state.
  logic [CNT_W-1:0]      pool_size;
  logic [CNT_W-1:0]      free_depth;
  logic [CNT_W-1:0]      low_mark;
  logic [CNT_W-1:0]      active_total;
  logic [CNT_W-1:0]      scan_pos;
  logic [31:0]           alloc_cnt;
  logic [31:0]           free_cnt;
  logic [31:0]           fail_cnt;
  logic [ROWS-1:0]       row_busy;

  // Item and scratch registers.
  mode_t                 item_mode;
  logic [9:0]            item_slot;
  logic [SLOT_W-1:0]     cur_slot;
  logic [ROW_W-1:0]      cur_row;
  logic                  stk_implicit;
  logic [SLOT_W-1:0]     stk_imp_val;
  status_t               res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic                  more_reg;

  // Memory ports.
  logic                  map_we;
  logic [ROW_W-1:0]      map_waddr;
  logic [MAP_WORD_W-1:0] map_wdata;
  logic [ROW_W-1:0]      map_raddr;
  logic [MAP_WORD_W-1:0] map_q;
  logic                  stk_we;
  logic [SLOT_W-1:0]     stk_waddr;
  logic [SLOT_W-1:0]     stk_raddr;
  logic [SLOT_W-1:0]     stk_q;

  // Derived values.
  logic [CNT_W-1:0]      cfg_pool;
  logic [ROW_W-1:0]      pos_row;
  logic [BIT_W-1:0]      pos_bit;
  logic [ROW_W-1:0]      item_row;
  logic [MAP_WORD_W-1:0] eff_word;
  logic [MAP_WORD_W-1:0] masked_word;
  logic [MAP_WORD_W-1:0] bit_mask;
  logic [ROWS-1:0]       row_above;
  logic [ROW_W-1:0]      next_row;
  logic [SLOT_W-1:0]     alloc_slot;
  logic [CNT_W-1:0]      hit_pos;
  logic [CNT_W-1:0]      scan2_pos;
  logic [CNT_W-1:0]      depth_dec;

  lfa_ram #(.WIDTH(MAP_WORD_W), .DEPTH(ROWS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  lfa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (cur_slot),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  // Pool size as written, clamped to the legal range.
  always_comb begin
    if (cfg_data == 11'd0) begin
      cfg_pool = CNT_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_SLOTS)) begin
      cfg_pool = CNT_W'(MAX_SLOTS);
    end else begin
      cfg_pool = CNT_W'(cfg_data);
    end
  end

  // Row and bit positions; a row whose busy flag is clear reads as empty.
  assign pos_row     = ROW_W'(scan_pos >> BIT_W);
  assign pos_bit     = BIT_W'(scan_pos);
  assign item_row    = ROW_W'(item_slot >> BIT_W);
  assign eff_word    = row_busy[cur_row] ? map_q : '0;
  assign masked_word = eff_word & ({MAP_WORD_W{1'b1}} << pos_bit);
  assign bit_mask    = MAP_WORD_W'(1) << BIT_W'(cur_slot);
  assign depth_dec   = free_depth - CNT_W'(1);
  assign alloc_slot  = stk_implicit ? stk_imp_val : stk_q;
  assign hit_pos     = (CNT_W'(cur_row) << BIT_W) | CNT_W'(first_set(masked_word));
  assign scan2_pos   = (CNT_W'(cur_row) << BIT_W) | CNT_W'(first_set(eff_word));

  // Busy rows above the current one, and the lowest of them.
  always_comb begin
    next_row = '0;
    for (int i = 0; i < ROWS; i++) begin
      row_above[i] = row_busy[i] && (i > int'(cur_row));
    end
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (row_above[i]) next_row = ROW_W'(i);
    end
  end

  // Read and write addresses for both memories.
  always_comb begin
    map_we    = 1'b0;
    map_waddr = cur_row;
    map_wdata = eff_word;
    map_raddr = pos_row;
    stk_we    = 1'b0;
    stk_waddr = SLOT_W'(free_depth);
    stk_raddr = SLOT_W'(depth_dec);
    case (op)
      OP_FETCH: begin
        if (item_mode == MODE_FREE) map_raddr = item_row;
      end
      OP_ALLOC_MAP: map_raddr = ROW_W'(alloc_slot >> BIT_W);
      OP_ALLOC_UPD: begin
        map_we    = 1'b1;
        map_wdata = eff_word | bit_mask;
      end
      OP_FREE_UPD: begin
        map_we    = flags.bit_set;
        map_wdata = eff_word & ~bit_mask;
        stk_we    = flags.bit_set;
      end
      OP_SCAN1: map_raddr = next_row;
      default: ;
    endcase
  end

  // Conditions for the controller.
  assign flags.mode       = item_mode;
  assign flags.depth_zero = (free_depth == '0);
  assign flags.slot_bad   = 32'(item_slot) >= 32'(pool_size);
  assign flags.pos_end    = (scan_pos >= pool_size);
  assign flags.bit_set    = |(eff_word & bit_mask);
  assign flags.word_hit   = |masked_word;
  assign flags.row_hit    = |row_above;

  // Pool state: cleared by reset and by a pool size write, else updated per operation.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      pool_size    <= rst ? RESET_POOL : cfg_pool;
      free_depth   <= rst ? RESET_POOL : cfg_pool;
      low_mark     <= rst ? RESET_POOL : cfg_pool;
      active_total <= '0;
      scan_pos     <= '0;
      alloc_cnt    <= '0;
      free_cnt     <= '0;
      fail_cnt     <= '0;
      row_busy     <= '0;
    end else begin
      case (op)
        OP_FETCH: begin
          case (item_mode)
            MODE_ALLOC: begin
              if (flags.depth_zero) begin
                fail_cnt <= sat_inc(fail_cnt);
              end else begin
                free_depth <= depth_dec;
                if (depth_dec < low_mark) low_mark <= depth_dec;
              end
            end
            MODE_NEXT: begin
              if (flags.pos_end) scan_pos <= pool_size;
            end
            MODE_REWIND: scan_pos <= '0;
            default: ;
          endcase
        end
        OP_ALLOC_MAP: begin
          active_total <= active_total + CNT_W'(1);
          alloc_cnt    <= sat_inc(alloc_cnt);
        end
        OP_ALLOC_UPD: row_busy[cur_row] <= 1'b1;
        OP_FREE_UPD: begin
          if (flags.bit_set) begin
            row_busy[cur_row] <= |map_wdata;
            free_depth        <= free_depth + CNT_W'(1);
            active_total      <= active_total - CNT_W'(1);
            free_cnt          <= sat_inc(free_cnt);
          end
        end
        OP_SCAN1: begin
          if (flags.word_hit) begin
            scan_pos <= hit_pos + CNT_W'(1);
          end else if (!flags.row_hit) begin
            scan_pos <= pool_size;
          end
        end
        OP_SCAN2: scan_pos <= scan2_pos + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Item and scratch registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        item_mode  <= mode_t'(in_mode);
        item_slot  <= in_slot;
        res_status <= STAT_OK;
        res_slot   <= '0;
      end
      OP_FETCH: begin
        stk_implicit <= (depth_dec < low_mark);
        stk_imp_val  <= SLOT_W'(pool_size - free_depth);
        cur_slot     <= SLOT_W'(item_slot);
        cur_row      <= (item_mode == MODE_FREE) ? item_row : pos_row;
        case (item_mode)
          MODE_ALLOC: if (flags.depth_zero) res_status <= STAT_EMPTY;
          MODE_FREE:  if (flags.slot_bad) res_status <= STAT_RANGE;
          MODE_NEXT:  if (flags.pos_end) res_status <= STAT_EXHAUSTED;
          default: ;
        endcase
      end
      OP_ALLOC_MAP: begin
        cur_slot <= alloc_slot;
        res_slot <= alloc_slot;
        cur_row  <= ROW_W'(alloc_slot >> BIT_W);
      end
      OP_FREE_UPD: begin
        if (!flags.bit_set) res_status <= STAT_INACTIVE;
      end
      OP_SCAN1: begin
        if (flags.word_hit) begin
          res_slot <= SLOT_W'(hit_pos);
        end else if (flags.row_hit) begin
          cur_row <= next_row;
        end else begin
          res_status <= STAT_EXHAUSTED;
        end
      end
      OP_SCAN2: res_slot <= SLOT_W'(scan2_pos);
      OP_CHECK: cur_row <= pos_row;
      OP_MORE:  more_reg <= (scan_pos < pool_size) && (flags.word_hit || flags.row_hit);
      default: ;
    endcase
  end

  // Result register, loaded when the output side has room.
  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      status       <= res_status;
      slot_out     <= 10'(res_slot);
      free_slots   <= 11'(free_depth);
      active_slots <= 11'(active_total);
      more_active  <= more_reg;
      alloc_total  <= alloc_cnt;
      free_total   <= free_cnt;
      fail_total   <= fail_cnt;
    end
  end

endmodule

[rtl/lfa_ctrl.sv]
// Controller: sequences each item through the datapath and owns the output valid flag.
module lfa_ctrl import lfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  dp_flags_t flags,
  output dp_op_t    op
);

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_FETCH;
      S_FETCH: begin
        case (flags.mode)
          MODE_ALLOC: state_next = flags.depth_zero ? S_CHECK : S_ALLOC_MAP;
          MODE_FREE:  state_next = flags.slot_bad ? S_CHECK : S_FREE_UPD;
          MODE_NEXT:  state_next = flags.pos_end ? S_CHECK : S_SCAN1;
          default:    state_next = S_CHECK;
        endcase
      end
      S_ALLOC_MAP: state_next = S_ALLOC_UPD;
      S_ALLOC_UPD: state_next = S_CHECK;
      S_FREE_UPD:  state_next = S_CHECK;
      S_SCAN1: begin
        state_next = (!flags.word_hit && flags.row_hit) ? S_SCAN2 : S_CHECK;
      end
      S_SCAN2: state_next = S_CHECK;
      S_CHECK: state_next = S_MORE;
      S_MORE:  state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: datapath operation, input ready and output valid.
  always_comb begin
    op            = OP_NONE;
    s_tready      = 1'b0;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) op = OP_LOAD;
      end
      S_FETCH:     op = OP_FETCH;
      S_ALLOC_MAP: op = OP_ALLOC_MAP;
      S_ALLOC_UPD: op = OP_ALLOC_UPD;
      S_FREE_UPD:  op = OP_FREE_UPD;
      S_SCAN1:     op = OP_SCAN1;
      S_SCAN2:     op = OP_SCAN2;
      S_CHECK:     op = OP_CHECK;
      S_MORE:      op = OP_MORE;
      S_OUT: begin
        if (out_free) begin
          op            = OP_OUT;
          m_tvalid_next = 1'b1;
        end
      end
      default: op = OP_NONE;
    endcase
  end

endmodule

[rtl/lifo_free_list_slot_allocator.sv]
// Each item passes fetch, its mode's states (allocate: map read, map update; free: free
// update; next-active: first scan, and second scan on a move to a later busy row; rewind
// or a failed check: none), check and look-ahead; the result waits for output room before
// a new item is taken. The single map row read port sets this order: each map access and
// the look-ahead take one registered read. Reset needs no clearing pass; a pool size write
// reinitializes the pool, the scan position and the event counters in the same cycle.
module lifo_free_list_slot_allocator import lfa_pkg::*; #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0: mode[1:0], slot[9:0], zero fill.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // Fields from bit 0: status[2:0], slot_out[9:0], free_slots[10:0], active_slots[10:0],
  // more_active, alloc_total[31:0], free_total[31:0], fail_total[31:0], zero fill.
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [10:0]           cfg_data
);

  dp_flags_t   flags;
  dp_op_t      op;
  status_t     status;
  logic [9:0]  slot_out;
  logic [10:0] free_slots;
  logic [10:0] active_slots;
  logic        more_active;
  logic [31:0] alloc_total;
  logic [31:0] free_total;
  logic [31:0] fail_total;

  // The pool size register takes a transfer in any cycle.
  assign cfg_ready = 1'b1;

  lfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .flags    (flags),
    .op       (op)
  );

  lfa_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid),
    .cfg_data     (cfg_data),
    .in_mode      (s_tdata[1:0]),
    .in_slot      (s_tdata[11:2]),
    .op           (op),
    .flags        (flags),
    .status       (status),
    .slot_out     (slot_out),
    .free_slots   (free_slots),
    .active_slots (active_slots),
    .more_active  (more_active),
    .alloc_total  (alloc_total),
    .free_total   (free_total),
    .fail_total   (fail_total)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = {4'b0000, fail_total, free_total, alloc_total, more_active,
                    active_slots, free_slots, slot_out, status};

endmodule
